/* rtl/a51kg_pkg.sv */
// Shared types, constants and the control store of the A5/1 keystream generator.
// Used by a51kg_lfsr_datapath, a51_keystream_generator_core and tb_top; no dependencies.
package a51kg_pkg;

    // Register lengths, majority bits and feedback taps of the three LFSRs.
    localparam int ONE_W   = 19;
    localparam int TWO_W   = 22;
    localparam int THREE_W = 23;

    localparam logic [ONE_W-1:0]   ONE_TAPS   = 19'h72000;
    localparam logic [TWO_W-1:0]   TWO_TAPS   = 22'h300000;
    localparam logic [THREE_W-1:0] THREE_TAPS = 23'h700080;

    localparam int ONE_MID   = 8;
    localparam int TWO_MID   = 10;
    localparam int THREE_MID = 10;

    // Setup loads the key and the frame number through one shift register.
    localparam int KEY_W       = 64;
    localparam int FRAME_W     = 22;
    localparam int LOAD_BITS   = KEY_W + FRAME_W;
    localparam int LOAD_W      = LOAD_BITS;

    // Loop counter covers the load length and any mixing count up to 255.
    localparam int CNT_W = 8;
    typedef logic [CNT_W-1:0] cnt_t;

    // Stream widths (byte padded).
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_MAJ
    } lfsr_op_t;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_LOAD_BITS,
        CNT_MIX
    } cnt_load_t;

    localparam int ADDR_W = 3;
    typedef logic [ADDR_W-1:0] step_t;

    // Control store addresses.
    localparam step_t ST_FETCH = 3'd0;
    localparam step_t ST_CLEAR = 3'd1;
    localparam step_t ST_LOAD  = 3'd2;
    localparam step_t ST_MIX   = 3'd3;
    localparam step_t ST_DONE  = 3'd4;
    localparam step_t ST_GEN   = 3'd5;

    typedef struct packed {
        lfsr_op_t  op;        // datapath operation of this step
        logic      fetch;     // step takes an input transaction
        logic      loop;      // repeat while the loop counter is nonzero
        logic      emit;      // step writes the output register
        logic      setup;     // emitted result acknowledges a setup
        cnt_load_t cnt_load;  // counter value loaded when the step ends
        step_t     next;      // sequential successor
        step_t     alt;       // jump target for a generate request at fetch
    } ucode_t;

    // Datapath control from the sequencer to the LFSR unit.
    typedef struct packed {
        lfsr_op_t op;
        logic     load_bit;
    } lfsr_ctrl_t;

    function automatic ucode_t ucode_rom(input step_t addr);
        ucode_t w;
        begin
            w = '{op: OP_NONE, fetch: 1'b0, loop: 1'b0, emit: 1'b0, setup: 1'b0,
                  cnt_load: CNT_KEEP, next: ST_FETCH, alt: ST_FETCH};
            unique case (addr)
                ST_FETCH:
                begin
                    w.fetch = 1'b1;
                    w.next  = ST_CLEAR;
                    w.alt   = ST_GEN;
                end
                ST_CLEAR:
                begin
                    w.op       = OP_CLEAR;
                    w.cnt_load = CNT_LOAD_BITS;
                    w.next     = ST_LOAD;
                end
                ST_LOAD:
                begin
                    w.op       = OP_LOAD;
                    w.loop     = 1'b1;
                    w.cnt_load = CNT_MIX;
                    w.next     = ST_MIX;
                end
                ST_MIX:
                begin
                    w.op   = OP_MAJ;
                    w.loop = 1'b1;
                    w.next = ST_DONE;
                end
                ST_DONE:
                begin
                    w.emit  = 1'b1;
                    w.setup = 1'b1;
                    w.next  = ST_FETCH;
                end
                ST_GEN:
                begin
                    w.op   = OP_MAJ;
                    w.emit = 1'b1;
                    w.next = ST_FETCH;
                end
                default:
                begin
                    w.next = ST_FETCH;
                end
            endcase
            return w;
        end
    endfunction

endpackage

/* rtl/a51kg_lfsr_datapath.sv */
// The three A5/1 shift registers with full and majority clocking.
// Depends on a51kg_pkg for register widths, taps and the control struct.
module a51kg_lfsr_datapath
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  a51kg_pkg::lfsr_ctrl_t ctrl,
    output logic                  keystream_next
);

    logic [a51kg_pkg::ONE_W-1:0]   one_reg,   one_next,   one_shift,   one_maj;
    logic [a51kg_pkg::TWO_W-1:0]   two_reg,   two_next,   two_shift,   two_maj;
    logic [a51kg_pkg::THREE_W-1:0] three_reg, three_next, three_shift, three_maj;
    logic                          mid_a, mid_b, mid_c, maj;

    always_comb
    begin
        one_shift   = {one_reg[a51kg_pkg::ONE_W-2:0], ^(one_reg & a51kg_pkg::ONE_TAPS)};
        two_shift   = {two_reg[a51kg_pkg::TWO_W-2:0], ^(two_reg & a51kg_pkg::TWO_TAPS)};
        three_shift = {three_reg[a51kg_pkg::THREE_W-2:0],
                       ^(three_reg & a51kg_pkg::THREE_TAPS)};

        mid_a = one_reg[a51kg_pkg::ONE_MID];
        mid_b = two_reg[a51kg_pkg::TWO_MID];
        mid_c = three_reg[a51kg_pkg::THREE_MID];
        maj   = (mid_a & mid_b) | (mid_a & mid_c) | (mid_b & mid_c);

        // A register steps only when its clocking bit agrees with the majority.
        one_maj   = (mid_a == maj) ? one_shift   : one_reg;
        two_maj   = (mid_b == maj) ? two_shift   : two_reg;
        three_maj = (mid_c == maj) ? three_shift : three_reg;

        keystream_next = one_maj[a51kg_pkg::ONE_W-1] ^ two_maj[a51kg_pkg::TWO_W-1]
                       ^ three_maj[a51kg_pkg::THREE_W-1];

        unique case (ctrl.op)
            a51kg_pkg::OP_CLEAR:
            begin
                one_next   = '0;
                two_next   = '0;
                three_next = '0;
            end
            a51kg_pkg::OP_LOAD:
            begin
                one_next   = one_shift   ^ {{(a51kg_pkg::ONE_W-1){1'b0}},   ctrl.load_bit};
                two_next   = two_shift   ^ {{(a51kg_pkg::TWO_W-1){1'b0}},   ctrl.load_bit};
                three_next = three_shift ^ {{(a51kg_pkg::THREE_W-1){1'b0}}, ctrl.load_bit};
            end
            a51kg_pkg::OP_MAJ:
            begin
                one_next   = one_maj;
                two_next   = two_maj;
                three_next = three_maj;
            end
            default:
            begin
                one_next   = one_reg;
                two_next   = two_reg;
                three_next = three_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_reg   <= '0;
            two_reg   <= '0;
            three_reg <= '0;
        end
        else
        begin
            one_reg   <= one_next;
            two_reg   <= two_next;
            three_reg <= three_next;
        end
    end

endmodule

/* rtl/a51_keystream_generator_core.sv */
// Top level of the A5/1 keystream generator: microcoded sequencer and stream ports.
// Depends on a51kg_pkg and a51kg_lfsr_datapath.
//
// A5/1 keystream generator. Write the 64-bit session key through cfg_we and
// cfg_wdata while the block is idle; bit i of the key is key byte i/8, bit i%8.
// Each input transaction carries a kind in s_axis_tuser. A setup transaction
// (kind 0) clears the three shift registers, loads the 64 key bits and then the
// 22-bit frame number from s_axis_tdata, least significant bit first, and runs
// MIX_CLOCKS majority clocks; it answers with one result whose tuser is 1 and
// whose keystream bit is 0. During a setup the sequencer runs one load or mixing
// clock per cycle, with no clock in the step that exits each loop. A generate
// transaction (kind 1) makes one majority clock and returns the keystream bit
// with tuser 0; it is fetched, then clocked with its result written in the
// generate step, which may wait for the output to free. The sequencer
// is a six-word control store with a step counter and a loop counter. The output
// register holds one finished result, so the next transaction is accepted while
// that result waits; a later result waits in its step until the output frees.
module a51_keystream_generator_core
#(
    parameter int MIX_CLOCKS = 100
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [21:0] frame_number, [23:22] zero
    input  logic        s_axis_tuser,   // [0] kind

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] keystream_bit, [7:1] zero
    output logic        m_axis_tuser    // [0] setup_done
);

    localparam a51kg_pkg::cnt_t MIX_CNT = a51kg_pkg::CNT_W'(MIX_CLOCKS);

    // Session key register; it is to be written only while idle, a rule the user keeps and the block leaves unchecked.
    logic [a51kg_pkg::KEY_W-1:0]  key_reg, key_next;

    // Sequencer state.
    a51kg_pkg::step_t             step_reg, step_next;
    a51kg_pkg::cnt_t              cnt_reg, cnt_next;
    a51kg_pkg::ucode_t            word;

    // Bits to load during setup: key first, then frame number, LSB first.
    logic [a51kg_pkg::LOAD_W-1:0] load_reg, load_next;

    // Output register.
    logic                         out_valid_reg, out_valid_next;
    logic                         out_ks_reg, out_ks_next;
    logic                         out_setup_reg, out_setup_next;

    logic                         out_free;
    logic                         in_accept;
    logic                         loop_done;
    logic                         stall;
    logic                         advance;
    logic                         do_op;
    logic                         keystream_next;
    a51kg_pkg::lfsr_ctrl_t        ctrl;

    a51kg_lfsr_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .keystream_next (keystream_next)
    );

    always_comb
    begin
        word      = a51kg_pkg::ucode_rom(step_reg);
        out_free  = !out_valid_reg || m_axis_tready;
        in_accept = word.fetch && s_axis_tvalid;
        loop_done = word.loop && (cnt_reg == '0);
        stall     = word.emit && !out_free;

        // A fetch step ends on a transaction, a loop step when its count is
        // spent, and any other step as soon as it is not held by the output.
        if (word.fetch)
        begin
            advance = in_accept;
        end
        else if (word.loop)
        begin
            advance = loop_done;
        end
        else
        begin
            advance = !stall;
        end

        do_op = word.loop ? !loop_done : (!word.fetch && !stall);

        ctrl.op       = do_op ? word.op : a51kg_pkg::OP_NONE;
        ctrl.load_bit = load_reg[0];

        s_axis_tready = word.fetch;

        // Step counter with the one conditional jump: generate requests.
        step_next = step_reg;
        if (advance)
        begin
            step_next = (word.fetch && s_axis_tuser) ? word.alt : word.next;
        end

        // Loop counter counts down while a loop runs; when a step ends it takes the value its word selects.
        cnt_next = cnt_reg;
        if (word.loop && !loop_done)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        else if (advance)
        begin
            case (word.cnt_load)
                a51kg_pkg::CNT_LOAD_BITS: cnt_next = a51kg_pkg::CNT_W'(a51kg_pkg::LOAD_BITS);
                a51kg_pkg::CNT_MIX:       cnt_next = MIX_CNT;
                default:                  cnt_next = cnt_reg;
            endcase
        end

        load_next = load_reg;
        if (in_accept)
        begin
            load_next = {s_axis_tdata[a51kg_pkg::FRAME_W-1:0], key_reg};
        end
        else if (ctrl.op == a51kg_pkg::OP_LOAD)
        begin
            load_next = {1'b0, load_reg[a51kg_pkg::LOAD_W-1:1]};
        end

        key_next = cfg_we ? cfg_wdata : key_reg;

        out_valid_next = out_valid_reg && !m_axis_tready;
        out_ks_next    = out_ks_reg;
        out_setup_next = out_setup_reg;
        if (word.emit && !stall)
        begin
            out_valid_next = 1'b1;
            out_ks_next    = word.setup ? 1'b0 : keystream_next;
            out_setup_next = word.setup;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= a51kg_pkg::ST_FETCH;
            cnt_reg       <= '0;
            key_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            key_reg       <= key_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        load_reg      <= load_next;
        out_ks_reg    <= out_ks_next;
        out_setup_reg <= out_setup_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(a51kg_pkg::M_TDATA_W-1){1'b0}}, out_ks_reg};
    assign m_axis_tuser  = out_setup_reg;

    // A setup request always enters the clearing step next.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> (step_reg == a51kg_pkg::ST_CLEAR))
    else $error("setup transaction did not start the clearing step");

    // Setup acknowledgements never carry a keystream bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[0] == 1'b0))
    else $error("setup result carries a nonzero keystream bit");

    // The mixing loop never counts beyond its configured length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == a51kg_pkg::ST_MIX) |-> (cnt_reg <= MIX_CNT))
    else $error("mixing loop counter out of range");

    // A result step never overwrites a result that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (word.emit && out_valid_reg && !m_axis_tready) |=> (step_reg == $past(step_reg)))
    else $error("result step advanced while the output was blocked");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the A5/1 keystream generator core.
// Depends on a51kg_pkg and a51_keystream_generator_core; holds its own LFSR predictor.
// Directed and random key setups and keystream requests run under random bus back-pressure in most phases.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MIX_CLOCKS    = 100;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 290;
    localparam int REPORT_LIMIT  = 100;

    // The request kind travels on s_axis_tuser.
    typedef enum logic
    {
        KIND_SETUP    = 1'b0,
        KIND_GENERATE = 1'b1
    } req_kind_t;

    typedef struct packed
    {
        req_kind_t                     kind;
        logic [a51kg_pkg::FRAME_W-1:0] frame;
    } ks_req_t;

    typedef struct packed
    {
        logic ks_bit;
        logic setup_done;
    } ks_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [63:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // [21:0] frame_number, [23:22] zero
    logic        s_axis_tuser = 1'b0; // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [0] keystream_bit, [7:1] zero
    logic        m_axis_tuser;        // [0] setup_done

    // Requests waiting to be sent, and results the predictor says are owed.
    ks_req_t    req_q[$];
    ks_result_t keystream_q[$];

    // Predictor state: the three shift registers and the key the next setup loads.
    logic [a51kg_pkg::ONE_W-1:0]   lfsr_a;
    logic [a51kg_pkg::TWO_W-1:0]   lfsr_b;
    logic [a51kg_pkg::THREE_W-1:0] lfsr_c;
    logic [a51kg_pkg::KEY_W-1:0]   key_shadow = '0;

    int         fail_count = 0;
    bit         idling_on = 1'b1;
    int         send_gap;
    int         hold_off;
    ks_req_t    next_req;
    ks_req_t    accepted_req;
    ks_result_t predicted;
    ks_result_t wanted;

    a51_keystream_generator_core #(
        .MIX_CLOCKS(MIX_CLOCKS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Shift the selected registers once; each feeds back the parity of its taps.
    task automatic shift_regs(input logic en_a, input logic en_b, input logic en_c);
        if (en_a)
            lfsr_a = {lfsr_a[a51kg_pkg::ONE_W-2:0], ^(lfsr_a & a51kg_pkg::ONE_TAPS)};
        if (en_b)
            lfsr_b = {lfsr_b[a51kg_pkg::TWO_W-2:0], ^(lfsr_b & a51kg_pkg::TWO_TAPS)};
        if (en_c)
            lfsr_c = {lfsr_c[a51kg_pkg::THREE_W-2:0], ^(lfsr_c & a51kg_pkg::THREE_TAPS)};
    endtask

    // A register moves only when its clocking bit agrees with the majority.
    task automatic shift_majority();
        logic a;
        logic b;
        logic c;
        logic maj;
        a   = lfsr_a[a51kg_pkg::ONE_MID];
        b   = lfsr_b[a51kg_pkg::TWO_MID];
        c   = lfsr_c[a51kg_pkg::THREE_MID];
        maj = (a & b) | (a & c) | (b & c);
        shift_regs(a == maj, b == maj, c == maj);
    endtask

    // Key and frame bits are shifted in with all three registers clocking.
    task automatic load_bit(input logic b);
        shift_regs(1'b1, 1'b1, 1'b1);
        lfsr_a[0] = lfsr_a[0] ^ b;
        lfsr_b[0] = lfsr_b[0] ^ b;
        lfsr_c[0] = lfsr_c[0] ^ b;
    endtask

    // Advances the predictor by one accepted request and returns the result it owes.
    task automatic predict_result(input ks_req_t req, output ks_result_t res);
        if (req.kind == KIND_SETUP)
        begin
            lfsr_a = '0;
            lfsr_b = '0;
            lfsr_c = '0;
            for (int i = 0; i < a51kg_pkg::KEY_W; i++)
                load_bit(key_shadow[i]);
            for (int i = 0; i < a51kg_pkg::FRAME_W; i++)
                load_bit(req.frame[i]);
            repeat (MIX_CLOCKS)
                shift_majority();
            res.ks_bit     = 1'b0;
            res.setup_done = 1'b1;
        end
        else
        begin
            shift_majority();
            res.ks_bit     = lfsr_a[a51kg_pkg::ONE_W-1] ^ lfsr_b[a51kg_pkg::TWO_W-1]
                           ^ lfsr_c[a51kg_pkg::THREE_W-1];
            res.setup_done = 1'b0;
        end
    endtask

    task automatic push_req(input req_kind_t kind, input logic [a51kg_pkg::FRAME_W-1:0] frame);
        ks_req_t r;
        r.kind  = kind;
        r.frame = frame;
        req_q.push_back(r);
    endtask

    function automatic logic [a51kg_pkg::FRAME_W-1:0] rand_frame();
        return a51kg_pkg::FRAME_W'($urandom_range(0, (1 << a51kg_pkg::FRAME_W) - 1));
    endfunction

    // The block is idle once nothing is queued, nothing is offered and every
    // result has come back. Checked at the falling edge so the clocked
    // processes have settled.
    task automatic wait_drained();
        @(negedge clk);
        while (req_q.size() != 0 || s_axis_tvalid || keystream_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Key writes happen only while the block is idle, so the predictor can
    // take the new key at the same moment.
    task automatic write_key(input logic [a51kg_pkg::KEY_W-1:0] key);
        @(posedge clk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= key;
        key_shadow = key;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Most of the random traffic is a setup followed by a run of generate
    // requests, which exercises real keystreams. About one choice in ten is a
    // lone request of random kind, which breaks runs up and lands setups in
    // the middle of a keystream. A phase may open with generate requests so
    // that a key change is seen not to disturb the running keystream.
    task automatic fill_random(input int n);
        int count;
        int run;
        count = 0;
        repeat ($urandom_range(0, 4))
        begin
            push_req(KIND_GENERATE, rand_frame());
            count++;
        end
        while (count < n)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                push_req(req_kind_t'($urandom_range(0, 1)), rand_frame());
                count++;
            end
            else
            begin
                push_req(KIND_SETUP, rand_frame());
                run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 30);
                repeat (run) push_req(KIND_GENERATE, rand_frame());
                count += run + 1;
            end
        end
    endtask

    task automatic note_mismatch(input string field, input logic exp_v, input logic act_v);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t ns: %s mismatch, expected %0b, actual %0b",
                     $time, field, exp_v, act_v);
    endtask

    // Request driver. A new transaction is offered only once the previous one
    // has been taken. Random gaps are inserted while idling is enabled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= KIND_SETUP;
            send_gap      <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (send_gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= $urandom_range(0, 7);
            end
            else if (req_q.size() != 0)
            begin
                next_req = req_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, next_req.frame};
                s_axis_tuser  <= next_req.kind;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure: tready drops for random bursts while idling is enabled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_off      <= 0;
        end
        else if (hold_off != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_off      <= hold_off - 1;
        end
        else if (idling_on && $urandom_range(0, 9) == 0)
        begin
            m_axis_tready <= 1'b0;
            hold_off      <= $urandom_range(0, 7);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor. A result can never leave on the edge its own request was
    // taken, so the result side is checked before the new prediction is queued.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (keystream_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t ns: unexpected result, expected none, %s %0b done %0b",
                                 $time, "actual bit", m_axis_tdata[0], m_axis_tuser);
                end
                else
                begin
                    wanted = keystream_q.pop_front();
                    if (m_axis_tdata[0] !== wanted.ks_bit)
                        note_mismatch("keystream_bit", wanted.ks_bit, m_axis_tdata[0]);
                    if (m_axis_tuser !== wanted.setup_done)
                        note_mismatch("setup_done", wanted.setup_done, m_axis_tuser);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                accepted_req.kind  = req_kind_t'(s_axis_tuser);
                accepted_req.frame = s_axis_tdata[a51kg_pkg::FRAME_W-1:0];
                predict_result(accepted_req, predicted);
                keystream_q.push_back(predicted);
            end
        end
    end

    initial
    begin
        lfsr_a = '0;
        lfsr_b = '0;
        lfsr_c = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Keystream requested before any setup: registers stay at zero.
        push_req(KIND_GENERATE, '0);
        push_req(KIND_GENERATE, '1);
        push_req(KIND_GENERATE, '0);
        // Setup with the reset key and frame zero, which also leaves all zeros.
        push_req(KIND_SETUP, '0);
        push_req(KIND_GENERATE, '0);
        push_req(KIND_GENERATE, '1);
        wait_drained();

        // All-ones key, largest frame, then new setups arriving mid-keystream.
        write_key('1);
        push_req(KIND_SETUP, '1);
        repeat (4) push_req(KIND_GENERATE, '0);
        push_req(KIND_SETUP, 22'h155555);
        repeat (3) push_req(KIND_GENERATE, '1);
        push_req(KIND_SETUP, 22'h2AAAAA);
        repeat (2) push_req(KIND_GENERATE, 22'h2AAAAA);
        wait_drained();

        // A key change must not touch the keystream until the next setup.
        write_key(64'h0123_4567_89AB_CDEF);
        repeat (3) push_req(KIND_GENERATE, '0);
        push_req(KIND_SETUP, 22'h000001);
        repeat (3) push_req(KIND_GENERATE, '0);
        wait_drained();

        // Random phases, each under its own key. One middle phase and the
        // final phase run with no idling on either side.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                write_key('0);
            else if (p == 1)
                write_key(64'h8000_0000_0000_0001);
            else
                write_key({$urandom(), $urandom()});
            idling_on = (p != 2) && (p != RANDOM_PHASES - 1);
            fill_random(PHASE_ITEMS);
            wait_drained();
        end

        repeat (16) @(negedge clk);
        if (fail_count == 0 && keystream_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog, several times the slowest legal run of all-setup traffic.
    initial
    begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* a51_keystream_generator_core.f */
rtl/a51kg_pkg.sv
rtl/a51kg_lfsr_datapath.sv
rtl/a51_keystream_generator_core.sv
verif/tb_top.sv
